FILE: rtl/gprt_pkg.sv
// Shared types, constants and register codes for the gamepad report translator.
`default_nettype none

package gprt_pkg;

  localparam int DEVICE_SLOTS = 5;
  localparam int SLOT_IDX_W   = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;

  localparam logic [7:0] REPORT_ID_GAMEPAD = 8'd1;

  localparam logic [7:0] DEADZONE_RST    = 8'd40;
  localparam logic [7:0] THRESHOLD_RST   = 8'd2;
  localparam logic       SPIN_EN_RST     = 1'b0;
  localparam logic [7:0] SPIN_LIMIT_RST  = 8'd12;
  localparam logic [7:0] AXIS_CENTER     = 8'd128;
  localparam logic [7:0] AXIS_FULL       = 8'd255;

  typedef enum logic [1:0] {
    CFG_DEADZONE   = 2'd0,
    CFG_THRESHOLD  = 2'd1,
    CFG_SPIN_EN    = 2'd2,
    CFG_SPIN_LIMIT = 2'd3
  } cfg_index_t;

  // key_bits positions
  localparam int KEY_SQUARE   = 0;
  localparam int KEY_CROSS    = 1;
  localparam int KEY_CIRCLE   = 2;
  localparam int KEY_TRIANGLE = 3;
  localparam int KEY_L1       = 4;
  localparam int KEY_R1       = 5;
  localparam int KEY_L2       = 6;
  localparam int KEY_R2       = 7;
  localparam int KEY_SHARE    = 8;
  localparam int KEY_OPTION   = 9;
  localparam int KEY_L3       = 10;
  localparam int KEY_R3       = 11;
  localparam int KEY_PS       = 12;
  localparam int KEY_PAD      = 13;

  typedef struct packed {
    logic [2:0]  device_slot;
    logic [7:0]  interface_number;
    logic [7:0]  report_kind;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [15:0] trigger_pair;
    logic [3:0]  hat;
    logic [13:0] key_bits;
    logic        touch_released;
    logic [23:0] touch_bytes;
  } report_t;

  typedef struct packed {
    logic slot_ok;
    logic changed;
  } store_status_t;

  typedef struct packed {
    logic [17:0] button_word;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
  } mapped_t;

endpackage

`default_nettype wire

FILE: rtl/gprt_store.sv
// Per-slot store of the last accepted report and the change detector.
`default_nettype none

module gprt_store (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire gprt_pkg::report_t      rpt,
  input  wire logic [7:0]             threshold,
  input  wire logic                   commit,
  output gprt_pkg::store_status_t     status
);
  import gprt_pkg::*;

  logic [47:0]           axes_r [DEVICE_SLOTS];
  logic [41:0]           keys_r [DEVICE_SLOTS];
  logic [SLOT_IDX_W-1:0] idx;
  logic [47:0]           axes_new;
  logic [41:0]           keys_new;
  logic [47:0]           axes_old;
  logic [5:0]            moved;

  assign idx      = SLOT_IDX_W'(rpt.device_slot - 3'd1);
  assign axes_new = {rpt.trigger_pair, rpt.right_y, rpt.right_x, rpt.left_y, rpt.left_x};
  assign keys_new = {rpt.touch_bytes, rpt.key_bits, rpt.hat};
  assign axes_old = axes_r[idx];

  always_comb begin
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    for (int i = 0; i < 6; i++) begin
      a = axes_new[8*i +: 8];
      b = axes_old[8*i +: 8];
      d = (a > b) ? (a - b) : (b - a);
      moved[i] = d > threshold;
    end
  end

  assign status.slot_ok = (rpt.device_slot != 3'd0) && (int'(rpt.device_slot) <= DEVICE_SLOTS);
  assign status.changed = (|moved) || (keys_new != keys_r[idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEVICE_SLOTS; i++) begin
        axes_r[i] <= '0;
        keys_r[i] <= '0;
      end
    end else if (commit) begin
      axes_r[idx] <= axes_new;
      keys_r[idx] <= keys_new;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gprt_map.sv
// Button word mapping with hat decode, and stick shaping with deadzone.
`default_nettype none

module gprt_map (
  input  wire gprt_pkg::report_t  rpt,
  input  wire logic [7:0]         deadzone,
  output gprt_pkg::mapped_t       mapped
);
  import gprt_pkg::*;

  logic [8:0]  dz_lo;
  logic [8:0]  dz_hi;
  logic        up, right, down, left;
  logic [13:0] k;

  assign dz_lo = {1'b0, AXIS_CENTER} - {2'b0, deadzone[7:1]};
  assign dz_hi = {1'b0, AXIS_CENTER} + {2'b0, deadzone[7:1]};

  function automatic logic [7:0] shape(input logic [7:0] a, input logic [8:0] lo,
                                       input logic [8:0] hi);
    logic [7:0] v;
    v = (a == 8'd0) ? 8'd1 : a;
    return (({1'b0, v} > lo) && ({1'b0, v} < hi)) ? AXIS_CENTER : v;
  endfunction

  assign up    = (rpt.hat == 4'd0) || (rpt.hat == 4'd1) || (rpt.hat == 4'd7);
  assign right = (rpt.hat >= 4'd1) && (rpt.hat <= 4'd3);
  assign down  = (rpt.hat >= 4'd3) && (rpt.hat <= 4'd5);
  assign left  = (rpt.hat >= 4'd5) && (rpt.hat <= 4'd7);
  assign k     = rpt.key_bits;

  assign mapped.button_word = {
    ~k[KEY_R3], ~k[KEY_L3], ~k[KEY_R1], ~k[KEY_L1], ~k[KEY_SQUARE], ~k[KEY_TRIANGLE],
    1'b0, ~k[KEY_PS], ~k[KEY_R2], ~k[KEY_L2], ~k[KEY_OPTION],
    ~(k[KEY_SHARE] | k[KEY_PAD]), ~k[KEY_CROSS], ~k[KEY_CIRCLE],
    ~left, ~down, ~right, ~up
  };

  assign mapped.left_x  = shape(rpt.left_x, dz_lo, dz_hi);
  assign mapped.left_y  = shape(AXIS_FULL - rpt.left_y, dz_lo, dz_hi);
  assign mapped.right_x = shape(rpt.right_x, dz_lo, dz_hi);
  assign mapped.right_y = shape(AXIS_FULL - rpt.right_y, dz_lo, dz_hi);

endmodule

`default_nettype wire

FILE: rtl/gprt_spinner.sv
// Touchpad drag spinner: clamped delta accumulation with wrap.
`default_nettype none

module gprt_spinner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        commit,
  input  wire logic        enable,
  input  wire logic [7:0]  step_limit,
  input  wire logic        released,
  input  wire logic [23:0] touch,
  output logic [7:0]       position_nxt
);

  logic [7:0]         pos_r;
  logic [11:0]        last_x_r;
  logic               dragging_r;
  logic [11:0]        tx;
  logic signed [12:0] delta;
  logic signed [12:0] lim;
  logic signed [12:0] dclamp;
  logic signed [9:0]  sum;
  logic signed [9:0]  wrapped;

  assign tx    = touch[11:0];
  assign delta = $signed({1'b0, tx}) - $signed({1'b0, last_x_r});
  assign lim   = $signed({5'b0, step_limit});

  always_comb begin
    dclamp = delta;
    if (delta > lim) dclamp = lim;
    if (delta < -lim) dclamp = -lim;
    sum = $signed({2'b0, pos_r}) + dclamp[9:0];
    wrapped = sum;
    if (sum > 10'sd255) wrapped = sum - 10'sd255;
    if (sum < 10'sd0) wrapped = sum + 10'sd256;
  end

  // advance only on a finger that was already dragging
  assign position_nxt = (enable && !released && dragging_r) ? wrapped[7:0] : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      last_x_r   <= '0;
      dragging_r <= 1'b0;
    end else if (commit && enable) begin
      if (!released) begin
        pos_r      <= position_nxt;
        last_x_r   <= tx;
        dragging_r <= 1'b1;
      end else begin
        dragging_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gamepad_report_translator.sv
// Top level of the gamepad report translator.
//
// Usage:
//   Input channel in_*: one decoded gamepad report per request. Reports with
//   an ID other than 1, with a device slot outside 1..DEVICE_SLOTS, or that
//   do not differ from the stored report of their slot are dropped without
//   a result. Every other report updates the slot store and the spinner and
//   yields exactly one request on out_*.
//   Config channel cfg_*: always ready; write only while no report is in
//   flight. Index 0 deadzone width, 1 change threshold, 2 spinner enable,
//   3 spinner step limit.
//   Path: an accepted report lands in the input register, and its result is
//   loaded into the result register, which drives out_*.
//   Throughput: one report per cycle unless out_* stalls; the input and result
//   registers around the combinational compare/map logic form a two-entry pipeline.
//   Stall: while out_valid is high and out_ready low the result holds; the input
//   register still loads while empty, then holds, and in_ready drops once full.
//   Reset (rst_n low, synchronous): the slot store, spinner state and the valid
//   flags of both pipeline stages clear; config registers return to defaults.
`default_nettype none

module gamepad_report_translator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // report channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_device_slot,
  input  wire logic [7:0]  in_interface_number,
  input  wire logic [7:0]  in_report_kind,
  input  wire logic [7:0]  in_left_x,
  input  wire logic [7:0]  in_left_y,
  input  wire logic [7:0]  in_right_x,
  input  wire logic [7:0]  in_right_y,
  input  wire logic [15:0] in_trigger_pair,
  input  wire logic [3:0]  in_hat,
  input  wire logic [13:0] in_key_bits,
  input  wire logic        in_touch_released,
  input  wire logic [23:0] in_touch_bytes,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_device,
  output logic [7:0]       out_interface,
  output logic [17:0]      out_button_word,
  output logic [7:0]       out_left_x,
  output logic [7:0]       out_left_y,
  output logic [7:0]       out_right_x,
  output logic [7:0]       out_right_y,
  output logic [7:0]       out_left_trigger,
  output logic [7:0]       out_right_trigger,
  output logic [7:0]       out_spinner_value,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import gprt_pkg::*;

  // configuration registers
  logic [7:0] deadzone_r;
  logic [7:0] threshold_r;
  logic       spin_en_r;
  logic [7:0] spin_limit_r;

  // input register stage
  logic          in_valid_r;
  report_t       rpt_r;
  report_t       rpt_in;

  // result register stage
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          advance;
  logic          hit;
  logic          commit;
  store_status_t status;
  mapped_t       mapped;
  logic [7:0]    spin_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r   <= DEADZONE_RST;
      threshold_r  <= THRESHOLD_RST;
      spin_en_r    <= SPIN_EN_RST;
      spin_limit_r <= SPIN_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEADZONE:   deadzone_r   <= cfg_data;
        CFG_THRESHOLD:  threshold_r  <= cfg_data;
        CFG_SPIN_EN:    spin_en_r    <= cfg_data[0];
        CFG_SPIN_LIMIT: spin_limit_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  assign rpt_in = '{
    device_slot:      in_device_slot,
    interface_number: in_interface_number,
    report_kind:      in_report_kind,
    left_x:           in_left_x,
    left_y:           in_left_y,
    right_x:          in_right_x,
    right_y:          in_right_y,
    trigger_pair:     in_trigger_pair,
    hat:              in_hat,
    key_bits:         in_key_bits,
    touch_released:   in_touch_released,
    touch_bytes:      in_touch_bytes
  };

  // advance the whole pipeline whenever the result register is free or drains
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rpt_r <= rpt_in;
    end
  end

  gprt_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rpt       (rpt_r),
    .threshold (threshold_r),
    .commit    (commit),
    .status    (status)
  );

  gprt_map u_map (
    .rpt      (rpt_r),
    .deadzone (deadzone_r),
    .mapped   (mapped)
  );

  gprt_spinner u_spinner (
    .clk          (clk),
    .rst_n        (rst_n),
    .commit       (commit),
    .enable       (spin_en_r),
    .step_limit   (spin_limit_r),
    .released     (rpt_r.touch_released),
    .touch        (rpt_r.touch_bytes),
    .position_nxt (spin_nxt)
  );

  // a report counts only with the gamepad ID, a valid slot and a real change;
  // the store and spinner update on the same edge that loads the result
  assign hit           = (rpt_r.report_kind == REPORT_ID_GAMEPAD) && status.slot_ok
                         && status.changed;
  assign commit        = in_valid_r && advance && hit;
  assign out_valid_nxt = in_valid_r && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_device        <= rpt_r.device_slot;
      out_interface     <= rpt_r.interface_number;
      out_button_word   <= mapped.button_word;
      out_left_x        <= mapped.left_x;
      out_left_y        <= mapped.left_y;
      out_right_x       <= mapped.right_x;
      out_right_y       <= mapped.right_y;
      out_left_trigger  <= rpt_r.trigger_pair[7:0];
      out_right_trigger <= rpt_r.trigger_pair[15:8];
      out_spinner_value <= spin_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/gprt_checker.sv
// Port-level assertions for the gamepad report translator, bound to the top level.
`default_nettype none

module gprt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_device,
  input wire logic [17:0] out_button_word,
  input wire logic [7:0]  out_left_x,
  input wire logic [7:0]  out_left_y,
  input wire logic [7:0]  out_right_x,
  input wire logic [7:0]  out_right_y,
  input wire logic [7:0]  out_spinner_value
);

  // results clear on reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_button_word)
      && $stable(out_left_x) && $stable(out_spinner_value) && $stable(out_device))
    else $error("stalled result changed");

  // zero lift keeps every stick output off zero
  a_axes_lifted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_x != 8'd0 && out_left_y != 8'd0
      && out_right_x != 8'd0 && out_right_y != 8'd0)
    else $error("stick output is zero");

  // fixed bit low, valid slot, hat never presses opposite directions
  a_button_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_button_word[11] && out_device != 3'd0
      && (out_button_word[0] || out_button_word[2])
      && (out_button_word[1] || out_button_word[3]))
    else $error("malformed button word or device");

endmodule

bind gamepad_report_translator gprt_checker u_gprt_checker (.*);

`default_nettype wire

FILE: bench/gamepad_report_translator_tb.sv
// Self-checking testbench for the gamepad report translator: directed and random reports.
`timescale 1ns / 100ps

module gamepad_report_translator_tb;
  import gprt_pkg::*;

  // Bail out after this many cycles in which no channel moves a request.
  localparam int QUIET_LIMIT = 2000;
  // Length of the forced result back-pressure stretch.
  localparam int HOLD_CYCLES = 80;
  // Reports offered in each random phase.
  localparam int PHASE_REPORTS = 225;
  localparam int PHASES = 6;

  typedef struct packed {
    logic [2:0]  device;
    logic [7:0]  iface;
    logic [17:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_trig;
    logic [7:0]  right_trig;
    logic [7:0]  spinner;
  } translation_t;

  // Tracks the slot store, spinner and registers, and holds the translations that
  // the block still owes us, oldest first.
  class translator_tracker;
    logic [47:0]  axes_store [DEVICE_SLOTS];
    logic [41:0]  keys_store [DEVICE_SLOTS];
    logic [7:0]   spin_pos;
    logic [11:0]  touch_anchor;
    bit           dragging;
    logic [7:0]   deadzone;
    logic [7:0]   threshold;
    bit           spin_on;
    logic [7:0]   spin_limit;
    translation_t pending_translations[$];
    int unsigned  mismatches;
    int unsigned  checked;

    function new();
      for (int i = 0; i < DEVICE_SLOTS; i++) begin
        axes_store[i] = '0;
        keys_store[i] = '0;
      end
      spin_pos     = '0;
      touch_anchor = '0;
      dragging     = 1'b0;
      deadzone     = DEADZONE_RST;
      threshold    = THRESHOLD_RST;
      spin_on      = SPIN_EN_RST;
      spin_limit   = SPIN_LIMIT_RST;
      mismatches   = 0;
      checked      = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [7:0] value);
      case (idx)
        CFG_DEADZONE:   deadzone   = value;
        CFG_THRESHOLD:  threshold  = value;
        CFG_SPIN_EN:    spin_on    = value[0];
        CFG_SPIN_LIMIT: spin_limit = value;
        default: ;
      endcase
    endfunction

    // Lift zero to one, then snap anything strictly inside the deadzone to center.
    function logic [7:0] shape(int a);
      int half;
      half = int'(deadzone) / 2;
      if (a == 0) a = 1;
      if (a > 128 - half && a < 128 + half) return AXIS_CENTER;
      return 8'(a);
    endfunction

    // Note one accepted report; returns 1 when it owes a translation.
    function bit note_report(report_t r);
      int          slot;
      int          diff;
      int          delta;
      int          lim;
      int          sum;
      bit          changed;
      bit          up, right, down, left;
      logic [47:0] axes;
      logic [41:0] keys;
      logic [17:0] bw;
      logic [13:0] k;
      logic [3:0]  h;
      logic [11:0] tx;
      translation_t t;

      if (r.report_kind != REPORT_ID_GAMEPAD || r.device_slot == 0 ||
          int'(r.device_slot) > DEVICE_SLOTS) return 1'b0;
      slot = int'(r.device_slot) - 1;
      axes = {r.trigger_pair, r.right_y, r.right_x, r.left_y, r.left_x};
      keys = {r.touch_bytes, r.key_bits, r.hat};
      changed = (keys != keys_store[slot]);
      for (int i = 0; i < 6; i++) begin
        diff = int'(axes[8*i +: 8]) - int'(axes_store[slot][8*i +: 8]);
        if (diff < 0) diff = -diff;
        if (diff > int'(threshold)) changed = 1'b1;
      end
      if (!changed) return 1'b0;
      axes_store[slot] = axes;
      keys_store[slot] = keys;

      k = r.key_bits;
      h = r.hat;
      up    = (h == 4'd0 || h == 4'd1 || h == 4'd7);
      right = (h >= 4'd1 && h <= 4'd3);
      down  = (h >= 4'd3 && h <= 4'd5);
      left  = (h >= 4'd5 && h <= 4'd7);
      bw     = '0;
      bw[17] = !k[KEY_R3];
      bw[16] = !k[KEY_L3];
      bw[15] = !k[KEY_R1];
      bw[14] = !k[KEY_L1];
      bw[13] = !k[KEY_SQUARE];
      bw[12] = !k[KEY_TRIANGLE];
      bw[10] = !k[KEY_PS];
      bw[9]  = !k[KEY_R2];
      bw[8]  = !k[KEY_L2];
      bw[7]  = !k[KEY_OPTION];
      bw[6]  = !(k[KEY_SHARE] | k[KEY_PAD]);
      bw[5]  = !k[KEY_CROSS];
      bw[4]  = !k[KEY_CIRCLE];
      bw[3]  = !left;
      bw[2]  = !down;
      bw[1]  = !right;
      bw[0]  = !up;

      if (spin_on) begin
        tx = r.touch_bytes[11:0];
        if (!r.touch_released) begin
          if (dragging) begin
            delta = int'(tx) - int'(touch_anchor);
            lim = int'(spin_limit);
            if (delta > lim) delta = lim;
            if (delta < -lim) delta = -lim;
            sum = int'(spin_pos) + delta;
            if (sum > 255) sum -= 255;
            if (sum < 0) sum += 256;
            spin_pos = 8'(sum);
          end
          touch_anchor = tx;
          dragging = 1'b1;
        end else begin
          dragging = 1'b0;
        end
      end

      t.device     = r.device_slot;
      t.iface      = r.interface_number;
      t.buttons    = bw;
      t.left_x     = shape(int'(r.left_x));
      t.left_y     = shape(int'(AXIS_FULL - r.left_y));
      t.right_x    = shape(int'(r.right_x));
      t.right_y    = shape(int'(AXIS_FULL - r.right_y));
      t.left_trig  = r.trigger_pair[7:0];
      t.right_trig = r.trigger_pair[15:8];
      t.spinner    = spin_pos;
      pending_translations.push_back(t);
      return 1'b1;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: mismatch at result %0d, %s: got %0h want %0h",
               $time, checked, what, got, want);
    endtask

    task check_translation(translation_t got);
      translation_t want;
      if (pending_translations.size() == 0) begin
        report_mismatch("unexpected result, device", 32'(got.device), '0);
      end else begin
        want = pending_translations.pop_front();
        if (got.device !== want.device)
          report_mismatch("device", 32'(got.device), 32'(want.device));
        if (got.iface !== want.iface)
          report_mismatch("interface", 32'(got.iface), 32'(want.iface));
        if (got.buttons !== want.buttons)
          report_mismatch("button word", 32'(got.buttons), 32'(want.buttons));
        if (got.left_x !== want.left_x)
          report_mismatch("left x", 32'(got.left_x), 32'(want.left_x));
        if (got.left_y !== want.left_y)
          report_mismatch("left y", 32'(got.left_y), 32'(want.left_y));
        if (got.right_x !== want.right_x)
          report_mismatch("right x", 32'(got.right_x), 32'(want.right_x));
        if (got.right_y !== want.right_y)
          report_mismatch("right y", 32'(got.right_y), 32'(want.right_y));
        if (got.left_trig !== want.left_trig)
          report_mismatch("left trigger", 32'(got.left_trig), 32'(want.left_trig));
        if (got.right_trig !== want.right_trig)
          report_mismatch("right trigger", 32'(got.right_trig), 32'(want.right_trig));
        if (got.spinner !== want.spinner)
          report_mismatch("spinner", 32'(got.spinner), 32'(want.spinner));
      end
      checked++;
    endtask

    task flush_check();
      if (pending_translations.size() != 0)
        report_mismatch("translations never delivered", pending_translations.size(), '0);
    endtask
  endclass

  // Clock and reset; every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_device_slot = '0;
  logic [7:0]  in_interface_number = '0;
  logic [7:0]  in_report_kind = '0;
  logic [7:0]  in_left_x = '0;
  logic [7:0]  in_left_y = '0;
  logic [7:0]  in_right_x = '0;
  logic [7:0]  in_right_y = '0;
  logic [15:0] in_trigger_pair = '0;
  logic [3:0]  in_hat = '0;
  logic [13:0] in_key_bits = '0;
  logic        in_touch_released = 1'b0;
  logic [23:0] in_touch_bytes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_device;
  logic [7:0]  out_interface;
  logic [17:0] out_button_word;
  logic [7:0]  out_left_x;
  logic [7:0]  out_left_y;
  logic [7:0]  out_right_x;
  logic [7:0]  out_right_y;
  logic [7:0]  out_left_trigger;
  logic [7:0]  out_right_trigger;
  logic [7:0]  out_spinner_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  translator_tracker tracker = new();

  // Idle odds in percent for each side, and the result hold-off request.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned cur_threshold = THRESHOLD_RST;
  int unsigned reports_offered = 0;
  int unsigned reg_writes = 0;
  int unsigned quiet_cycles = 0;
  report_t     slot_history [8];

  always #4 clk = ~clk;

  gamepad_report_translator u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_device_slot      (in_device_slot),
    .in_interface_number (in_interface_number),
    .in_report_kind      (in_report_kind),
    .in_left_x           (in_left_x),
    .in_left_y           (in_left_y),
    .in_right_x          (in_right_x),
    .in_right_y          (in_right_y),
    .in_trigger_pair     (in_trigger_pair),
    .in_hat              (in_hat),
    .in_key_bits         (in_key_bits),
    .in_touch_released   (in_touch_released),
    .in_touch_bytes      (in_touch_bytes),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_device          (out_device),
    .out_interface       (out_interface),
    .out_button_word     (out_button_word),
    .out_left_x          (out_left_x),
    .out_left_y          (out_left_y),
    .out_right_x         (out_right_x),
    .out_right_y         (out_right_y),
    .out_left_trigger    (out_left_trigger),
    .out_right_trigger   (out_right_trigger),
    .out_spinner_value   (out_spinner_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Offer one report: idle first at random, then hold valid and payload until the
  // request is taken. Valid is only lowered inside an idle gap, so back-to-back
  // reports keep it high without a drop in the same step.
  task automatic offer(input report_t r, output bit yields);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_device_slot      <= r.device_slot;
    in_interface_number <= r.interface_number;
    in_report_kind      <= r.report_kind;
    in_left_x           <= r.left_x;
    in_left_y           <= r.left_y;
    in_right_x          <= r.right_x;
    in_right_y          <= r.right_y;
    in_trigger_pair     <= r.trigger_pair;
    in_hat              <= r.hat;
    in_key_bits         <= r.key_bits;
    in_touch_released   <= r.touch_released;
    in_touch_bytes      <= r.touch_bytes;
    do @(posedge clk); while (!in_ready);
    yields = tracker.note_report(r);
    reports_offered++;
  endtask

  // Write one register; wait on the clock afterwards so cfg_valid never drops and
  // rises in the same step.
  task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_register(idx, value);
    reg_writes++;
    @(posedge clk);
  endtask

  // Stop offering and wait for every owed translation, then let the pipeline run
  // on so a dropped report still in flight clears out.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_translations.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input int phase);
    logic [7:0] dz, thr, lim;
    bit         en;
    case (phase)
      0: begin dz = DEADZONE_RST; thr = THRESHOLD_RST; en = 1'b1; lim = SPIN_LIMIT_RST; end
      1: begin dz = 8'd0;   thr = 8'd0;   en = 1'b1; lim = 8'd0;   end
      2: begin dz = 8'd254; thr = 8'd255; en = 1'b1; lim = 8'd255; end
      3: begin
        dz = 8'($urandom_range(0, 254));
        thr = 8'($urandom_range(0, 8));
        en = 1'b0;
        lim = 8'($urandom);
      end
      4: begin
        dz = 8'($urandom_range(0, 254));
        thr = 8'($urandom_range(0, 8));
        en = 1'b1;
        lim = 8'($urandom_range(1, 40));
      end
      default: begin dz = 8'd2; thr = 8'd1; en = 1'b1; lim = 8'd1; end
    endcase
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_SPIN_EN, {7'd0, en});
    write_reg(CFG_SPIN_LIMIT, lim);
    cur_threshold = 32'(thr);
  endtask

  function automatic report_t blank(input int slot);
    report_t r;
    r = '0;
    r.device_slot = 3'(slot);
    r.report_kind = REPORT_ID_GAMEPAD;
    return r;
  endfunction

  // Move an axis right at the threshold, just past it, a little, or anywhere.
  function automatic logic [7:0] nudge(input logic [7:0] old, input int unsigned thr);
    int m;
    int v;
    case ($urandom_range(0, 4))
      0: m = int'(thr);
      1: m = int'(thr) + 1;
      2: m = int'($urandom_range(0, 255));
      default: m = int'($urandom_range(0, 3));
    endcase
    v = $urandom_range(0, 1) ? int'(old) + m : int'(old) - m;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Mostly a well-formed report that edits the last one sent to its slot; the
  // rest is raw noise, foreign report IDs, bad slots and plain repeats.
  function automatic report_t make_report(input int unsigned thr);
    report_t       r;
    logic [127:0]  noise;
    logic [47:0]   axes;
    int unsigned   pick;
    int unsigned   slot;
    int unsigned   kind;
    pick = $urandom_range(0, 99);
    slot = $urandom_range(1, DEVICE_SLOTS);
    r = slot_history[slot];
    r.device_slot = 3'(slot);
    r.report_kind = REPORT_ID_GAMEPAD;
    r.interface_number = 8'($urandom);
    if (pick < 8) begin
      noise = {$urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(report_t)-1:0];
    end else if (pick < 14) begin
      kind = $urandom_range(0, 254);
      if (kind >= 1) kind++;
      r.report_kind = 8'(kind);
    end else if (pick < 18) begin
      slot = $urandom_range(0, 2);
      r.device_slot = (slot == 0) ? 3'd0 : 3'(DEVICE_SLOTS + slot);
    end else if (pick < 24) begin
      r.touch_released = 1'($urandom);
    end else begin
      axes = {r.trigger_pair, r.right_y, r.right_x, r.left_y, r.left_x};
      for (int i = 0; i < 6; i++)
        if ($urandom_range(0, 99) < 30) axes[8*i +: 8] = nudge(axes[8*i +: 8], thr);
      {r.trigger_pair, r.right_y, r.right_x, r.left_y, r.left_x} = axes;
      if ($urandom_range(0, 99) < 20) r.hat = 4'($urandom);
      if ($urandom_range(0, 99) < 30) r.key_bits[$urandom_range(0, 13)] ^= 1'b1;
      else if ($urandom_range(0, 99) < 5) r.key_bits = 14'($urandom);
      if ($urandom_range(0, 99) < 35) begin
        r.touch_released = ($urandom_range(0, 3) == 0);
        r.touch_bytes[11:0] = r.touch_bytes[11:0] + 12'($urandom_range(0, 400)) - 12'd200;
        if ($urandom_range(0, 99) < 10) r.touch_bytes[23:12] = 12'($urandom);
      end
    end
    if (r.device_slot != 0 && int'(r.device_slot) <= DEVICE_SLOTS)
      slot_history[r.device_slot] = r;
    return r;
  endfunction

  // Result side: random back-pressure, plus one long hold-off on request that
  // counts its own cycles so the block fills up and stalls its input.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Check every result taken by the sink against the oldest owed translation.
  always @(posedge clk) begin
    translation_t got;
    if (rst_n && out_valid && out_ready) begin
      got.device     = out_device;
      got.iface      = out_interface;
      got.buttons    = out_button_word;
      got.left_x     = out_left_x;
      got.left_y     = out_left_y;
      got.right_x    = out_right_x;
      got.right_y    = out_right_y;
      got.left_trig  = out_left_trigger;
      got.right_trig = out_right_trigger;
      got.spinner    = out_spinner_value;
      tracker.check_translation(got);
    end
  end

  // Watchdog: count cycles in which no channel moves a request.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("[gamepad_report_translator] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    report_t     r;
    bit          yields;
    bit          pressure_armed;
    int unsigned made;
    int unsigned owed;

    pressure_armed = 1'b1;
    owed = 0;
    for (int i = 0; i < 8; i++) slot_history[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 48;

    // Directed part, reset register values. Drop: foreign report ID, slot zero
    // and slots above range, and a report equal to the cleared store.
    r = blank(1); r.report_kind = 8'd0; r.left_x = 8'd200; offer(r, yields);
    r = blank(0); r.hat = 4'd3; offer(r, yields);
    r = blank(6); r.hat = 4'd3; offer(r, yields);
    r = blank(7); r.key_bits = '1; offer(r, yields);
    r = blank(1); offer(r, yields);
    // All fields at their maximum, then an axis moved by exactly the threshold
    // (dropped) and by one more (taken).
    r = '1; r.device_slot = 3'd1; r.report_kind = REPORT_ID_GAMEPAD; offer(r, yields);
    r.left_x = 8'd253; offer(r, yields);
    r.left_x = 8'd252; offer(r, yields);
    // Touch bytes alone count as a change; the release flag alone does not.
    r = blank(5); r.touch_bytes = 24'h000001; offer(r, yields);
    r.touch_released = 1'b1; offer(r, yields);
    // Walk the hat through codes 0 to 13 and each key bit alone, with sticks on
    // both sides of the deadzone edges.
    for (int h = 0; h < 14; h++) begin
      r = blank(2);
      r.hat = 4'(h);
      r.key_bits = 14'(1 << h);
      r.left_x = 8'd108;
      r.left_y = 8'd146;
      r.right_x = 8'd147;
      r.right_y = 8'd107;
      r.trigger_pair = 16'h00ff;
      offer(r, yields);
    end
    // Share and pad share a bit; a zero axis lifts to one.
    r = blank(3);
    r.key_bits = 14'((1 << KEY_SHARE) | (1 << KEY_PAD));
    r.interface_number = 8'hff;
    r.left_y = 8'hff;
    offer(r, yields);
    r = blank(4);
    r.trigger_pair = 16'hff00;
    r.left_x = AXIS_CENTER;
    r.right_x = AXIS_CENTER;
    r.hat = 4'd15;
    offer(r, yields);

    // Random phases, each under its own register setting. Idle profile: sender
    // light / receiver heavy, then swapped, then none at all.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      apply_setting(phase);
      if (phase < 2) begin
        send_idle_pct = 28;
        recv_idle_pct = 48;
      end else if (phase < 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      made = 0;
      while (made < PHASE_REPORTS) begin
        r = make_report(cur_threshold);
        offer(r, yields);
        made++;
        owed += yields;
        // Once, with no idling, starve the result side and keep offering.
        if (phase == 4 && made == 100 && pressure_armed) begin
          pressure_armed = 1'b0;
          hold_request = 1'b1;
        end
      end
    end

    settle();
    repeat (6) @(posedge clk);
    tracker.flush_check();
    $display("covered %0d reports and %0d translations over %0d register writes",
             reports_offered, tracker.checked, reg_writes);
    $display("random reports owed %0d translations; settings hit deadzone and threshold %s",
             owed, "extremes, and one long stall");
    if (tracker.mismatches == 0) begin
      $display("[gamepad_report_translator] OK");
    end else begin
      $display("[gamepad_report_translator] ERROR");
    end
    $finish;
  end

endmodule
